// ===== src/bbc_pkg.sv =====
// Shared types, constants and bracket decode for the bracket balance checker.
`timescale 1ns / 1ps
package bbc_pkg;

	localparam int STACK_DEPTH = 128;
	localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;
	localparam logic [7:0] CH_LSQUARE = 8'h5b;
	localparam logic [7:0] CH_RSQUARE = 8'h5d;

	typedef enum logic [1:0] {
		CODE_PAREN  = 2'd0,
		CODE_BRACE  = 2'd1,
		CODE_SQUARE = 2'd2,
		CODE_CLOSER = 2'd3
	} bbc_code_t;

	localparam int CODE_W = $bits(bbc_code_t);

	typedef struct packed {
		logic      is_open;
		logic      is_close;
		bbc_code_t code;     // opener code, or the opener a closer wants
	} bbc_decode_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		bbc_code_t         wdata;
		logic [ADDR_W-1:0] raddr;
	} bbc_mem_req_t;

	typedef struct packed {
		logic [7:0] depth;
		logic       balanced;
		logic       overflowed;
		logic       verdict_final;
	} bbc_result_t;

	function automatic bbc_decode_t bbc_decode(input logic [7:0] ch);
		bbc_decode_t d;
		d = '{is_open: 1'b0, is_close: 1'b0, code: CODE_PAREN};
		unique case (ch)
			CH_LPAREN:  d = '{is_open: 1'b1, is_close: 1'b0, code: CODE_PAREN};
			CH_LBRACE:  d = '{is_open: 1'b1, is_close: 1'b0, code: CODE_BRACE};
			CH_LSQUARE: d = '{is_open: 1'b1, is_close: 1'b0, code: CODE_SQUARE};
			CH_RPAREN:  d = '{is_open: 1'b0, is_close: 1'b1, code: CODE_PAREN};
			CH_RBRACE:  d = '{is_open: 1'b0, is_close: 1'b1, code: CODE_BRACE};
			CH_RSQUARE: d = '{is_open: 1'b0, is_close: 1'b1, code: CODE_SQUARE};
			default:    d = '{is_open: 1'b0, is_close: 1'b0, code: CODE_PAREN};
		endcase
		return d;
	endfunction

endpackage

// ===== src/bbc_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
`timescale 1ns / 1ps
module bbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/bbc_stack_ctrl.sv =====
// Stack control: level and overflow state, top-of-stack read-modify-write.
`timescale 1ns / 1ps
module bbc_stack_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [7:0]                  char_in,
	input  logic                        end_of_text,
	input  logic [bbc_pkg::CODE_W-1:0]  rdata,
	output bbc_pkg::bbc_mem_req_t       mem_req,
	output bbc_pkg::bbc_result_t        result
);
	import bbc_pkg::*;

	logic [LVL_W-1:0] level_q;
	logic             ovf_q;
	logic             fwd_q;
	bbc_code_t        fwd_data_q;

	bbc_decode_t      dec;
	bbc_code_t        top_code;
	logic             full;
	logic             empty;
	logic [LVL_W-1:0] lvl_dec;
	logic [LVL_W-1:0] lvl_nx;
	logic             ovf_nx;
	logic [LVL_W-1:0] lvl_after;
	logic [LVL_W-1:0] lvl_after_dec;
	logic             ovf_after;

	// Top entry was read last cycle at level-1; a write to that entry in the
	// same cycle is taken from the forward register instead.
	assign top_code = fwd_q ? fwd_data_q : bbc_code_t'(rdata);
	assign dec      = bbc_decode(char_in);
	assign full     = (level_q == LVL_W'(STACK_DEPTH));
	assign empty    = (level_q == '0);
	assign lvl_dec  = level_q - LVL_W'(1);

	always_comb begin
		lvl_nx        = level_q;
		ovf_nx        = ovf_q;
		mem_req.we    = 1'b0;
		mem_req.waddr = level_q[ADDR_W-1:0];
		mem_req.wdata = dec.code;
		if (accept) begin
			if (dec.is_open) begin
				if (full) begin
					ovf_nx = 1'b1;
				end else begin
					mem_req.we = 1'b1;
					lvl_nx     = level_q + LVL_W'(1);
				end
			end else if (dec.is_close) begin
				if (empty) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = '0;
					mem_req.wdata = CODE_CLOSER;
					lvl_nx        = LVL_W'(1);
				end else if (top_code == dec.code) begin
					lvl_nx = lvl_dec;
				end else begin
					// mismatch: top entry replaced by a closer mark, level kept
					mem_req.we    = 1'b1;
					mem_req.waddr = lvl_dec[ADDR_W-1:0];
					mem_req.wdata = CODE_CLOSER;
				end
			end
		end
		lvl_after     = (accept && end_of_text) ? '0 : lvl_nx;
		ovf_after     = (accept && end_of_text) ? 1'b0 : ovf_nx;
		lvl_after_dec = lvl_after - LVL_W'(1);
		mem_req.raddr = lvl_after_dec[ADDR_W-1:0];
	end

	assign result.depth         = 8'(lvl_nx);
	assign result.balanced      = (lvl_nx == '0) && !ovf_nx;
	assign result.overflowed    = ovf_nx;
	assign result.verdict_final = end_of_text;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			ovf_q   <= 1'b0;
			fwd_q   <= 1'b0;
		end else begin
			level_q <= lvl_after;
			ovf_q   <= ovf_after;
			fwd_q   <= mem_req.we && (mem_req.waddr == mem_req.raddr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= mem_req.wdata;
	end

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LVL_W'(STACK_DEPTH))
		else $error("stack level beyond depth");

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_text |=> level_q == '0 && !ovf_q)
		else $error("state not cleared after last transaction");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q && !(accept && end_of_text) |=> ovf_q)
		else $error("overflow flag dropped before end of text");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && dec.is_open && !full && !end_of_text |=>
			level_q == $past(level_q) + LVL_W'(1))
		else $error("push did not grow the stack");

endmodule

// ===== src/bracket_balance_checker.sv =====
// Result: registered; appears on the master side in the cycle after its input transaction.
// Throughput: one character per cycle unless the output stalls; the stack top comes from the
//   single RAM read port, addressed ahead, with a forward register for same-entry writes.
// Reset: clears stack level, overflow flag and output valid; the stack RAM itself
//   is not cleared (entries are read only after being pushed).
`timescale 1ns / 1ps
module bracket_balance_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_in[7:0]
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // depth[7:0], balanced[8], overflowed[9], zero[15:10]
	output logic        m_tlast    // verdict_final
);
	import bbc_pkg::*;

	logic                s_accept;
	bbc_mem_req_t        mem_req;
	logic [CODE_W-1:0]   rdata;
	bbc_result_t         result;
	logic                m_valid_q;
	bbc_result_t         result_q;

	assign s_tready = !m_valid_q || m_tready;
	assign s_accept = s_tvalid && s_tready;

	bbc_stack_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (s_accept),
		.char_in     (s_tdata),
		.end_of_text (s_tlast),
		.rdata       (rdata),
		.mem_req     (mem_req),
		.result      (result)
	);

	bbc_ram #(
		.WIDTH (CODE_W),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_accept) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			result_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'b0, result_q.overflowed, result_q.balanced, result_q.depth};
	assign m_tlast  = result_q.verdict_final;

endmodule
